// ===== rtl/alm_pkg.sv =====
// ---------------------------------------------------------------------------
// alm_pkg: shared types and codes for the array linked list manager
// Sequencer states, operation codes and result status codes.
// ---------------------------------------------------------------------------
`default_nettype none

package alm_pkg;

   // operation codes carried on req_tuser
   localparam logic [1:0] FUNC_INS_POS  = 2'd0;
   localparam logic [1:0] FUNC_DEL_POS  = 2'd1;
   localparam logic [1:0] FUNC_INS_SLOT = 2'd2;
   localparam logic [1:0] FUNC_DEL_SLOT = 2'd3;

   // result status carried on rsp_tuser
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ILLEGAL = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_WALK,
      ST_INS_RD0,
      ST_INS_RD1,
      ST_INS_WR0,
      ST_INS_WR1,
      ST_DEL_RD,
      ST_DEL_WR0,
      ST_DEL_WR1,
      ST_DONE
   } alm_state_type;

endpackage

`default_nettype wire

// ===== rtl/alm_ram.sv =====
// ---------------------------------------------------------------------------
// alm_ram: single write port, single registered read port memory
// Holds one link or flag array of the slot store.
// ---------------------------------------------------------------------------
`default_nettype none

module alm_ram #(
   parameter  int WIDTH = 6,
   parameter  int DEPTH = 64,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/array_linked_list_manager_unit.sv =====
// ---------------------------------------------------------------------------
// array_linked_list_manager_unit: doubly linked list over a slot store
// Sentinel-based circular list with a free chain, driven by a sequencer.
// ---------------------------------------------------------------------------
// Usage
//   req channel: one operation per transfer. req_tuser holds the operation
//   (insert after position, delete at position, insert after slot, delete
//   slot); req_tdata holds position, slot and the data word.
//   rsp channel: one result per operation. rsp_tuser holds the status
//   (ok, illegal, full); rsp_tdata holds slot used, size, head and tail.
//   Operations at position 0 or 1 go straight to the update; at p >= 2 the
//   walk reads one next link per cycle from the link memory. Rejected
//   operations skip the update. Result is registered and shows up in the
//   same cycle req_tready returns.
//   One item is in flight at a time: req_tready is high only when idle.
//   Reset: after reset the block sweeps the slot memories once, one slot a
//   cycle, SLOTS cycles, with req_tready low; then it is ready.
//   Stall: a result waits in the output register while rsp_tready is low;
//   the next item may be taken meanwhile, but its result is held back until
//   the register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module array_linked_list_manager_unit #(
   parameter int SLOTS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [5:0] position, [11:6] slot, [43:12] value, [47:44] zero
   input  wire logic [47:0] req_tdata,
   // [1:0] func
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [5:0] slot_used, [11:6] size_now, [17:12] head_slot, [23:18] tail_slot
   output logic      [23:0] rsp_tdata,
   // [1:0] status
   output logic      [1:0]  rsp_tuser
);

   localparam int SW = $clog2(SLOTS);          // slot index width
   localparam int PW = (SW > 6) ? SW : 6;      // position compare width
   localparam int CW = SW + 7;                 // slot range compare width

   // widen or trim an index to the 6-bit result fields
   function automatic logic [5:0] to_field(input logic [SW-1:0] x);
      logic [SW+5:0] w;
      w = {6'b0, x};
      return w[5:0];
   endfunction

   // request fields
   logic [1:0]        req_func;
   logic [5:0]        req_position;
   logic [5:0]        req_slot;
   logic signed [31:0] req_value;

   assign req_func     = req_tuser;
   assign req_position = req_tdata[5:0];
   assign req_slot     = req_tdata[11:6];
   assign req_value    = req_tdata[43:12];

   // sequencer and list state
   alm_pkg::alm_state_type state_ff, state_in;
   logic [SW-1:0] clr_ff, clr_in;
   logic [SW-1:0] free_head_ff, free_head_in;
   logic [SW-1:0] count_ff, count_in;
   logic [SW-1:0] head_ff, head_in;       // mirror of next link of sentinel
   logic [SW-1:0] tail_ff, tail_in;       // mirror of prev link of sentinel

   logic [PW-1:0] pos_w;
   logic [PW-1:0] cnt_w;
   logic [CW-1:0] slot_w;

   assign pos_w  = PW'(req_position);
   assign cnt_w  = PW'(count_ff);
   assign slot_w = CW'(req_slot);

   // per-operation working registers
   logic [1:0]        func_ff, func_in;
   logic [SW-1:0]     pos_ff, pos_in;
   logic [SW-1:0]     slot_ff, slot_in;
   logic              slot_ok_ff, slot_ok_in;
   logic signed [31:0] value_ff, value_in;
   logic [SW-1:0]     k_ff, k_in;
   logic [SW-1:0]     target_ff, target_in;
   logic [SW-1:0]     succ_ff, succ_in;
   logic [SW-1:0]     used_ff, used_in;
   logic [1:0]        status_ff, status_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;
   logic        rsp_load;

   // shared incrementer / decrementer
   logic [SW-1:0] add_a;
   logic          add_dec;
   logic [SW-1:0] add_sum;

   assign add_sum = add_a + (add_dec ? {SW{1'b1}} : SW'(1));

   // memory ports
   logic          nx_we, pv_we, us_we, dt_we;
   logic [SW-1:0] nx_waddr, pv_waddr, us_waddr, dt_waddr;
   logic [SW-1:0] nx_wdata, pv_wdata;
   logic          us_wdata;
   logic [31:0]   dt_wdata;
   logic [SW-1:0] nx_raddr, pv_raddr, us_raddr;
   logic [SW-1:0] nx_rdata, pv_rdata;
   logic          us_rdata;

   logic full;
   logic pos_legal;
   logic chk_legal;

   assign full = (free_head_ff == '0);

   alm_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_next_ram (
      .clock   (clock),
      .wr_en   (nx_we),
      .wr_addr (nx_waddr),
      .wr_data (nx_wdata),
      .rd_addr (nx_raddr),
      .rd_data (nx_rdata)
   );

   alm_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (pv_we),
      .wr_addr (pv_waddr),
      .wr_data (pv_wdata),
      .rd_addr (pv_raddr),
      .rd_data (pv_rdata)
   );

   alm_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_use_ram (
      .clock   (clock),
      .wr_en   (us_we),
      .wr_addr (us_waddr),
      .wr_data (us_wdata),
      .rd_addr (us_raddr),
      .rd_data (us_rdata)
   );

   // data words: written on insert, cleared on delete
   logic [31:0] slot_data_mem [SLOTS];

   always_ff @(posedge clock) begin
      if (dt_we) begin
         slot_data_mem[dt_waddr] <= dt_wdata;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= alm_pkg::ST_CLEAR;
         clr_ff       <= '0;
         free_head_ff <= SW'(1);
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      pos_ff      <= pos_in;
      slot_ff     <= slot_in;
      slot_ok_ff  <= slot_ok_in;
      value_ff    <= value_in;
      k_ff        <= k_in;
      target_ff   <= target_in;
      succ_ff     <= succ_in;
      used_ff     <= used_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // result register: load when the sequencer finishes, drop on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = status_ff;
         rsp_data_in  = {to_field(tail_ff), to_field(head_ff),
                         to_field(count_ff), to_field(used_ff)};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      free_head_in = free_head_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      func_in      = func_ff;
      pos_in       = pos_ff;
      slot_in      = slot_ff;
      slot_ok_in   = slot_ok_ff;
      value_in     = value_ff;
      k_in         = k_ff;
      target_in    = target_ff;
      succ_in      = succ_ff;
      used_in      = used_ff;
      status_in    = status_ff;
      req_tready   = 1'b0;
      rsp_load     = 1'b0;
      add_a        = count_ff;
      add_dec      = 1'b0;
      pos_legal    = 1'b0;
      chk_legal    = 1'b0;
      nx_we = 1'b0;  nx_waddr = '0;  nx_wdata = '0;  nx_raddr = '0;
      pv_we = 1'b0;  pv_waddr = '0;  pv_wdata = '0;  pv_raddr = '0;
      us_we = 1'b0;  us_waddr = '0;  us_wdata = 1'b0; us_raddr = '0;
      dt_we = 1'b0;  dt_waddr = '0;  dt_wdata = '0;

      case (state_ff)
         alm_pkg::ST_CLEAR: begin
            // rebuild the free chain, one slot a cycle
            add_a    = clr_ff;
            nx_we    = 1'b1;
            nx_waddr = clr_ff;
            nx_wdata = (clr_ff != '0 && clr_ff != SW'(SLOTS - 1)) ? add_sum : '0;
            pv_we    = 1'b1;
            pv_waddr = clr_ff;
            us_we    = 1'b1;
            us_waddr = clr_ff;
            us_wdata = (clr_ff == '0);
            dt_we    = 1'b1;
            dt_waddr = clr_ff;
            clr_in   = add_sum;
            if (clr_ff == SW'(SLOTS - 1)) begin
               state_in = alm_pkg::ST_IDLE;
            end
         end

         alm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               func_in    = req_func;
               pos_in     = pos_w[SW-1:0];
               slot_in    = slot_w[SW-1:0];
               slot_ok_in = (slot_w < CW'(SLOTS));
               value_in   = req_value;
               used_in    = '0;
               if (req_func == alm_pkg::FUNC_INS_POS ||
                   req_func == alm_pkg::FUNC_DEL_POS) begin
                  if (req_func == alm_pkg::FUNC_INS_POS) begin
                     pos_legal = (pos_w <= cnt_w);
                  end else begin
                     pos_legal = (pos_w != '0) && (pos_w <= cnt_w);
                  end
                  if (!pos_legal) begin
                     status_in = alm_pkg::STATUS_ILLEGAL;
                     state_in  = alm_pkg::ST_DONE;
                  end else if (req_func == alm_pkg::FUNC_INS_POS && full) begin
                     status_in = alm_pkg::STATUS_FULL;
                     state_in  = alm_pkg::ST_DONE;
                  end else if (pos_w == '0) begin
                     // front insert: after the sentinel
                     target_in = '0;
                     state_in  = alm_pkg::ST_INS_RD0;
                  end else if (pos_w == PW'(1)) begin
                     target_in = head_ff;
                     state_in  = (req_func == alm_pkg::FUNC_INS_POS) ?
                                 alm_pkg::ST_INS_RD0 : alm_pkg::ST_DEL_RD;
                  end else begin
                     nx_raddr = head_ff;
                     k_in     = SW'(1);
                     state_in = alm_pkg::ST_WALK;
                  end
               end else begin
                  us_raddr = slot_w[SW-1:0];
                  state_in = alm_pkg::ST_CHECK;
               end
            end
         end

         alm_pkg::ST_WALK: begin
            // nx_rdata holds the slot at position k+1
            add_a = k_ff;
            if (add_sum == pos_ff) begin
               target_in = nx_rdata;
               state_in  = (func_ff == alm_pkg::FUNC_INS_POS) ?
                           alm_pkg::ST_INS_RD0 : alm_pkg::ST_DEL_RD;
            end else begin
               nx_raddr = nx_rdata;
               k_in     = add_sum;
            end
         end

         alm_pkg::ST_CHECK: begin
            chk_legal = slot_ok_ff && us_rdata &&
                        !(func_ff == alm_pkg::FUNC_DEL_SLOT && slot_ff == '0);
            target_in = slot_ff;
            if (!chk_legal) begin
               status_in = alm_pkg::STATUS_ILLEGAL;
               state_in  = alm_pkg::ST_DONE;
            end else if (func_ff == alm_pkg::FUNC_INS_SLOT) begin
               if (full) begin
                  status_in = alm_pkg::STATUS_FULL;
                  state_in  = alm_pkg::ST_DONE;
               end else begin
                  state_in = alm_pkg::ST_INS_RD0;
               end
            end else begin
               state_in = alm_pkg::ST_DEL_RD;
            end
         end

         alm_pkg::ST_INS_RD0: begin
            nx_raddr = target_ff;
            state_in = alm_pkg::ST_INS_RD1;
         end

         alm_pkg::ST_INS_RD1: begin
            succ_in  = nx_rdata;
            nx_raddr = free_head_ff;
            state_in = alm_pkg::ST_INS_WR0;
         end

         alm_pkg::ST_INS_WR0: begin
            // fill the new slot and pop it off the free chain
            nx_we        = 1'b1;
            nx_waddr     = free_head_ff;
            nx_wdata     = succ_ff;
            pv_we        = 1'b1;
            pv_waddr     = free_head_ff;
            pv_wdata     = target_ff;
            us_we        = 1'b1;
            us_waddr     = free_head_ff;
            us_wdata     = 1'b1;
            dt_we        = 1'b1;
            dt_waddr     = free_head_ff;
            dt_wdata     = value_ff;
            used_in      = free_head_ff;
            free_head_in = nx_rdata;
            state_in     = alm_pkg::ST_INS_WR1;
         end

         alm_pkg::ST_INS_WR1: begin
            // splice between target and its successor
            nx_we     = 1'b1;
            nx_waddr  = target_ff;
            nx_wdata  = used_ff;
            pv_we     = 1'b1;
            pv_waddr  = succ_ff;
            pv_wdata  = used_ff;
            count_in  = add_sum;
            status_in = alm_pkg::STATUS_OK;
            if (target_ff == '0) begin
               head_in = used_ff;
            end
            if (succ_ff == '0) begin
               tail_in = used_ff;
            end
            state_in = alm_pkg::ST_DONE;
         end

         alm_pkg::ST_DEL_RD: begin
            nx_raddr = target_ff;
            pv_raddr = target_ff;
            state_in = alm_pkg::ST_DEL_WR0;
         end

         alm_pkg::ST_DEL_WR0: begin
            // bridge predecessor and successor
            nx_we    = 1'b1;
            nx_waddr = pv_rdata;
            nx_wdata = nx_rdata;
            pv_we    = 1'b1;
            pv_waddr = nx_rdata;
            pv_wdata = pv_rdata;
            if (pv_rdata == '0) begin
               head_in = nx_rdata;
            end
            if (nx_rdata == '0) begin
               tail_in = pv_rdata;
            end
            state_in = alm_pkg::ST_DEL_WR1;
         end

         alm_pkg::ST_DEL_WR1: begin
            // push the freed slot onto the free chain
            nx_we        = 1'b1;
            nx_waddr     = target_ff;
            nx_wdata     = free_head_ff;
            pv_we        = 1'b1;
            pv_waddr     = target_ff;
            us_we        = 1'b1;
            us_waddr     = target_ff;
            dt_we        = 1'b1;
            dt_waddr     = target_ff;
            free_head_in = target_ff;
            add_dec      = 1'b1;
            count_in     = add_sum;
            used_in      = target_ff;
            status_in    = alm_pkg::STATUS_OK;
            state_in     = alm_pkg::ST_DONE;
         end

         alm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = alm_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = alm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/alm_checker.sv =====
// ---------------------------------------------------------------------------
// alm_checker: port-level checks for the linked list manager
// Watches the request and result channels; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module alm_checker #(
   parameter int SLOTS = 64
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // one operation at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready high straight after a transfer");

   // failed operations report no slot, and status stays in range
   a_err_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != alm_pkg::STATUS_OK |->
         rsp_tdata[5:0] == 6'd0 && rsp_tuser != 2'd3)
      else $error("bad status or slot on failed operation");

   // empty list has no head and no tail, and the other way round
   a_empty_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && SLOTS <= 64 |->
         (rsp_tdata[11:6] == 6'd0) == (rsp_tdata[17:12] == 6'd0) &&
         (rsp_tdata[11:6] == 6'd0) == (rsp_tdata[23:18] == 6'd0))
      else $error("size, head and tail disagree on empty list");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind array_linked_list_manager_unit alm_checker #(.SLOTS(SLOTS)) u_alm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
